// ----- rtl/derb_pkg.sv -----
// Package: shared types and constants for the double-ended ring buffer.
`timescale 1ns / 1ps
`default_nettype none
package derb_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int CAP_W     = 5;
    localparam int DATA_W    = 8;
    localparam int POS_W     = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_READ       = 3'd4,
        CMD_CLEAR      = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_INDEX = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WAIT = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  pos;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [CAP_W-1:0] fill;
        logic             ovw;
        logic             use_data;
    } t_resp;

endpackage
`default_nettype wire

// ----- rtl/derb_engine.sv -----
// Ring pointers, fill count and cell memory; decodes and executes one command per accept.
`timescale 1ns / 1ps
`default_nettype none
module derb_engine #(
    parameter int DEPTH = derb_pkg::DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr,
    input  wire logic [derb_pkg::CAP_W-1:0]  i_capacity,
    input  wire logic                        i_accept,
    input  wire derb_pkg::t_req              i_req,
    output derb_pkg::t_resp                  o_resp,
    output logic [derb_pkg::DATA_W-1:0]      o_rd_data
);
    import derb_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int SW = ((PW > CAP_W) ? PW : CAP_W) + 1;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [PW-1:0]     r_front, r_back;
    logic [CAP_W-1:0]  r_count;
    logic [PW-1:0]     n_front, n_back;
    logic [CAP_W-1:0]  n_count;

    logic [CAP_W-1:0]  cap_c;
    logic [SW-1:0]     cap_s, front_s, back_s, sum_s;
    logic              full;
    logic              mem_we, mem_re;
    logic [PW-1:0]     waddr, raddr;

    function automatic logic [SW-1:0] f_inc(input logic [SW-1:0] p, input logic [SW-1:0] c);
        logic [SW-1:0] s;
        s = p + SW'(1);
        return (s >= c) ? '0 : s;
    endfunction

    function automatic logic [SW-1:0] f_dec(input logic [SW-1:0] p, input logic [SW-1:0] c);
        return (p == '0 || p >= c) ? c - SW'(1) : p - SW'(1);
    endfunction

    always_comb begin
        cap_c   = (32'(i_capacity) > 32'(DEPTH)) ? CAP_W'(DEPTH) : i_capacity;
        cap_s   = SW'(cap_c);
        front_s = SW'(r_front);
        back_s  = SW'(r_back);
        full    = (SW'(r_count) >= cap_s);
        sum_s   = front_s + SW'(i_req.pos);
        if (sum_s >= cap_s) begin
            sum_s = sum_s - cap_s;
        end

        n_front = r_front;
        n_back  = r_back;
        n_count = r_count;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        waddr   = r_back;
        raddr   = r_back;
        o_resp.status   = ST_OK;
        o_resp.ovw      = 1'b0;
        o_resp.use_data = 1'b0;

        unique case (i_req.cmd)
            CMD_PUSH_BACK: begin
                if (cap_c == '0) begin
                    o_resp.status = ST_ZERO;
                end else begin
                    n_back = (r_count != '0) ? PW'(f_inc(back_s, cap_s)) : r_back;
                    mem_we = 1'b1;
                    waddr  = n_back;
                    if (full) begin
                        n_front    = PW'(f_inc(front_s, cap_s));
                        o_resp.ovw = 1'b1;
                    end else begin
                        n_count = r_count + CAP_W'(1);
                    end
                end
            end
            CMD_PUSH_FRONT: begin
                if (cap_c == '0) begin
                    o_resp.status = ST_ZERO;
                end else begin
                    n_front = (r_count != '0) ? PW'(f_dec(front_s, cap_s)) : r_front;
                    mem_we  = 1'b1;
                    waddr   = n_front;
                    if (full) begin
                        n_back     = PW'(f_dec(back_s, cap_s));
                        o_resp.ovw = 1'b1;
                    end else begin
                        n_count = r_count + CAP_W'(1);
                    end
                end
            end
            CMD_POP_BACK: begin
                if (r_count == '0) begin
                    o_resp.status = ST_EMPTY;
                end else begin
                    mem_re          = 1'b1;
                    raddr           = r_back;
                    o_resp.use_data = 1'b1;
                    n_count         = r_count - CAP_W'(1);
                    n_back = (n_count == '0) ? r_front : PW'(f_dec(back_s, cap_s));
                end
            end
            CMD_POP_FRONT: begin
                if (r_count == '0) begin
                    o_resp.status = ST_EMPTY;
                end else begin
                    mem_re          = 1'b1;
                    raddr           = r_front;
                    o_resp.use_data = 1'b1;
                    n_count         = r_count - CAP_W'(1);
                    n_front = (n_count == '0) ? r_back : PW'(f_inc(front_s, cap_s));
                end
            end
            CMD_READ: begin
                if (SW'(i_req.pos) >= SW'(r_count)) begin
                    o_resp.status = ST_INDEX;
                end else begin
                    mem_re          = 1'b1;
                    raddr           = PW'(sum_s);
                    o_resp.use_data = 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
                n_back  = r_front;
            end
            default: begin
            end
        endcase
        o_resp.fill = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_cfg_wr) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && mem_we) begin
            r_mem[waddr] <= i_req.data;
        end
        if (i_accept && mem_re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ----- rtl/double_ended_ring_buffer_top.sv -----
// Top level: stream ports, APB capacity register, result register and command sequencing.
// A result is held as pending on accept, then moves to the output register once it is free.
// Throughput: one command per cycle while the result side takes every word;
//   a command waits only while the previous result is stuck in the output register.
// The cell memory is read at the accepting edge; the output register then loads once it is free.
// Reset (synchronous, active low) empties the buffer and sets capacity to 16.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_ring_buffer_top #(
    parameter int DEPTH = derb_pkg::DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic      [31:0] o_prdata,
    output logic             o_pready,
    // command words
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,  // command[2:0], data_in[10:3], position[14:11]
    // result words
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata   // data_out[7:0], status[9:8], fill_count[14:10],
                                         // overwrote[15]
);
    import derb_pkg::*;

    logic [CAP_W-1:0]  r_cap;
    t_state            r_state, n_state;
    t_req              req;
    t_resp             resp;
    t_resp             r_p_resp;
    logic [DATA_W-1:0] rd_data;
    logic              r_m_valid;
    logic [15:0]       r_m_data;
    logic              cfg_wr, accept, out_free, load_out;
    logic [DATA_W-1:0] out_byte;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && (i_paddr[2] == 1'b0);
    assign o_prdata = (i_paddr[2] == 1'b0) ? {{(32-CAP_W){1'b0}}, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= i_pwdata[CAP_W-1:0];
        end
    end

    assign req.cmd  = t_cmd'(i_s_tdata[2:0]);
    assign req.data = i_s_tdata[10:3];
    assign req.pos  = i_s_tdata[14:11];

    derb_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (cfg_wr),
        .i_capacity (r_cap),
        .i_accept   (accept),
        .i_req      (req),
        .o_resp     (resp),
        .o_rd_data  (rd_data)
    );

    always_comb begin
        out_free   = !r_m_valid || i_m_tready;
        load_out   = (r_state == S_WAIT) && out_free;
        o_s_tready = (r_state == S_IDLE) || out_free;
        accept     = i_s_tvalid && o_s_tready;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                n_state = accept ? S_WAIT : S_IDLE;
            end
            S_WAIT: begin
                if (load_out) begin
                    n_state = accept ? S_WAIT : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign out_byte = r_p_resp.use_data ? rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_resp <= resp;
        end
        if (load_out) begin
            r_m_data <= {r_p_resp.ovw, r_p_resp.fill, r_p_resp.status, out_byte};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

`ifndef NO_ASSERTIONS
    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[9:8] != ST_OK) |-> (o_m_tdata[7:0] == 8'd0))
        else $error("error result carries data");

    a_ovw_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[15]) |-> (o_m_tdata[9:8] == ST_OK))
        else $error("overwrite flagged on failed command");

    a_zero_cap_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[9:8] == ST_ZERO) |-> (o_m_tdata[14:10] == 5'd0))
        else $error("zero capacity with nonzero fill");

    a_accept_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_WAIT))
        else $error("accepted word not pending");
`endif

endmodule
`default_nettype wire

// ----- bench/tb_double_ended_ring_buffer_top.sv -----
// Testbench: self-checking stream test of the double-ended ring buffer top level.
`timescale 1ns / 1ps
module tb_double_ended_ring_buffer_top;
    import derb_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [2:0] CAP_ADDR     = 3'd0;
    localparam int         MAX_SHOWN    = 10;

    typedef struct packed {
        logic [7:0]       data;
        t_status          status;
        logic [CAP_W-1:0] fill;
        logic             ovw;
    } t_ring_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // command[2:0], data_in[10:3], position[14:11]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // data_out[7:0], status[9:8], fill_count[14:10], overwrote[15]

    // buffer image kept alongside the block
    logic [7:0] ring_cells [DEPTH_DEF];
    int         head;
    int         tail;
    int         held;
    int         cap_reg;

    t_ring_word due_results[$];
    int         mismatches;
    int         burst_left;
    bit         gaps_on;
    int         ready_mode;
    int         hold_req;
    int         hold_left;
    logic [15:0] ready_pat;
    int         ready_tick;

    double_ended_ring_buffer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic int ring_next(int p, int c);
        return (p + 1 >= c) ? 0 : p + 1;
    endfunction

    function automatic int ring_prev(int p, int c);
        return (p == 0 || p >= c) ? c - 1 : p - 1;
    endfunction

    task automatic apply_to_ring(input logic [2:0] cmd, input logic [7:0] din,
                                 input logic [3:0] pos);
        int         c;
        int         p;
        bit         full;
        t_ring_word w;
        c = (cap_reg > DEPTH_DEF) ? DEPTH_DEF : cap_reg;
        full = (held >= c);
        w.data = 8'h00;
        w.status = ST_OK;
        w.ovw = 1'b0;
        case (cmd)
            CMD_PUSH_BACK: begin
                if (c == 0) begin
                    w.status = ST_ZERO;
                end else begin
                    if (held != 0) tail = ring_next(tail, c);
                    ring_cells[tail] = din;
                    if (full) begin
                        head = ring_next(head, c);
                        w.ovw = 1'b1;
                    end else begin
                        held++;
                    end
                end
            end
            CMD_PUSH_FRONT: begin
                if (c == 0) begin
                    w.status = ST_ZERO;
                end else begin
                    if (held != 0) head = ring_prev(head, c);
                    ring_cells[head] = din;
                    if (full) begin
                        tail = ring_prev(tail, c);
                        w.ovw = 1'b1;
                    end else begin
                        held++;
                    end
                end
            end
            CMD_POP_BACK: begin
                if (held == 0) begin
                    w.status = ST_EMPTY;
                end else begin
                    w.data = ring_cells[tail];
                    held--;
                    tail = (held == 0) ? head : ring_prev(tail, c);
                end
            end
            CMD_POP_FRONT: begin
                if (held == 0) begin
                    w.status = ST_EMPTY;
                end else begin
                    w.data = ring_cells[head];
                    held--;
                    head = (held == 0) ? tail : ring_next(head, c);
                end
            end
            CMD_READ: begin
                if (int'(pos) >= held) begin
                    w.status = ST_INDEX;
                end else begin
                    p = head + int'(pos);
                    if (p >= c) p -= c;
                    w.data = ring_cells[p];
                end
            end
            CMD_CLEAR: begin
                held = 0;
                tail = head;
            end
            default: ;
        endcase
        w.fill = held[CAP_W-1:0];
        due_results.insert(due_results.size(), w);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_ring_word want;
        t_ring_word got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.data   = o_m_tdata[7:0];
            got.status = t_status'(o_m_tdata[9:8]);
            got.fill   = o_m_tdata[14:10];
            got.ovw    = o_m_tdata[15];
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: unexpected result word %h", $realtime, o_m_tdata);
            end else begin
                want = due_results[0];
                due_results.delete(0);
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"%0t: mismatch data %h/%h status %0d/%0d",
                                  " fill %0d/%0d ovw %b/%b (exp/got)"},
                                 $realtime, want.data, got.data, want.status, got.status,
                                 want.fill, got.fill, want.ovw, got.ovw);
                end
            end
        end
    end

    // result-side stalls, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        ready_tick++;
        ready_pat = {ready_pat[14:0], ready_pat[15]};
        if (ready_tick % 16 == 0) begin
            ready_pat = 16'($urandom());
            if (ready_pat == 16'h0000) ready_pat = 16'h0001;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready = 1'b0;
        end else if (ready_mode == 0) begin
            i_m_tready = 1'b1;
        end else begin
            i_m_tready = ready_pat[0];
        end
    end

    task automatic send_cmd(input logic [2:0] cmd, input logic [7:0] din,
                            input logic [3:0] pos);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata = {1'b0, pos, din, cmd};
        do @(posedge i_clk); while (!o_s_tready);
        apply_to_ring(cmd, din, pos);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [4:0] v);
        drain_results();
        @(negedge i_clk);
        i_psel = 1'b1;
        i_penable = 1'b0;
        i_pwrite = 1'b1;
        i_paddr = CAP_ADDR;
        i_pwdata = {27'd0, v};
        @(negedge i_clk);
        i_penable = 1'b1;
        do @(posedge i_clk); while (!o_pready);
        cap_reg = int'(v);
        head = 0;
        tail = 0;
        held = 0;
        @(negedge i_clk);
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
    endtask

    task automatic random_cmd(input int push_pct, input int pop_pct);
        int         r;
        logic [2:0] c;
        logic [3:0] p;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            c = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        else if (r < push_pct + pop_pct)
            c = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        else if (r < 96)
            c = CMD_READ;
        else if (r < 98)
            c = CMD_CLEAR;
        else
            c = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        if (held != 0 && $urandom_range(0, 3) != 0)
            p = 4'($urandom_range(0, held - 1));
        else
            p = 4'($urandom_range(0, 15));
        send_cmd(c, 8'($urandom_range(0, 255)), p);
    endtask

    task automatic test_empty_and_spare();
        send_cmd(CMD_POP_BACK, 8'h00, 4'd0);
        send_cmd(CMD_POP_FRONT, 8'hFF, 4'd0);
        send_cmd(CMD_READ, 8'h00, 4'd15);
        send_cmd(CMD_CLEAR, 8'h00, 4'd0);
        send_cmd(CMD_SPARE_LO, 8'hA5, 4'd5);
        send_cmd(CMD_SPARE_HI, 8'h5A, 4'd10);
    endtask

    task automatic test_both_ends();
        send_cmd(CMD_PUSH_BACK, 8'h00, 4'd0);
        send_cmd(CMD_PUSH_FRONT, 8'hFF, 4'd0);
        send_cmd(CMD_READ, 8'h00, 4'd0);
        send_cmd(CMD_READ, 8'h00, 4'd1);
        send_cmd(CMD_READ, 8'h00, 4'd2);
        send_cmd(CMD_POP_BACK, 8'h00, 4'd0);
        send_cmd(CMD_POP_FRONT, 8'h00, 4'd0);
    endtask

    task automatic test_zero_capacity();
        write_capacity(5'd0);
        send_cmd(CMD_PUSH_BACK, 8'h11, 4'd0);
        send_cmd(CMD_PUSH_FRONT, 8'h22, 4'd0);
        send_cmd(CMD_POP_FRONT, 8'h00, 4'd0);
        send_cmd(CMD_READ, 8'h00, 4'd0);
    endtask

    task automatic test_overwrite_when_full();
        write_capacity(5'd1);
        send_cmd(CMD_PUSH_BACK, 8'h3C, 4'd0);
        send_cmd(CMD_PUSH_BACK, 8'hC3, 4'd0);
        send_cmd(CMD_PUSH_FRONT, 8'h81, 4'd0);
        send_cmd(CMD_READ, 8'h00, 4'd0);
        send_cmd(CMD_POP_FRONT, 8'h00, 4'd0);
        write_capacity(5'd31);
        send_cmd(CMD_PUSH_FRONT, 8'h7E, 4'd0);
        send_cmd(CMD_READ, 8'h00, 4'd0);
    endtask

    task automatic test_random_phases();
        logic [4:0] caps [12];
        int         push_mix [3];
        int         pop_mix [3];
        caps = '{5'd16, 5'd31, 5'd1, 5'd2, 5'd0, 5'd17, 5'd3, 5'd8, 5'd16, 5'd5, 5'd0, 5'd0};
        push_mix = '{60, 45, 30};
        pop_mix = '{25, 40, 55};
        caps[10] = 5'($urandom_range(0, 31));
        caps[11] = 5'($urandom_range(2, 16));
        for (int ph = 0; ph < 12; ph++) begin
            write_capacity(caps[ph]);
            gaps_on = (ph % 3 != 1);
            ready_mode = (ph % 4 != 0) ? 1 : 0;
            repeat (145) random_cmd(push_mix[ph % 3], pop_mix[ph % 3]);
        end
        gaps_on = 1'b1;
        ready_mode = 1;
    endtask

    task automatic test_output_backpressure();
        write_capacity(5'd16);
        gaps_on = 1'b0;
        hold_req = 120;
        repeat (60) random_cmd(50, 20);
        gaps_on = 1'b1;
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        i_paddr = CAP_ADDR;
        i_pwdata = 32'd0;
        i_s_tvalid = 1'b0;
        i_s_tdata = 16'd0;
        i_m_tready = 1'b0;
        mismatches = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        ready_mode = 1;
        hold_req = 0;
        hold_left = 0;
        ready_pat = 16'hB5E3;
        ready_tick = 0;
        head = 0;
        tail = 0;
        held = 0;
        cap_reg = int'(CAP_RESET);
        for (int k = 0; k < DEPTH_DEF; k++) ring_cells[k] = 8'h00;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_and_spare();
        test_both_ends();
        test_zero_capacity();
        test_overwrite_when_full();
        test_random_phases();
        test_output_backpressure();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- double_ended_ring_buffer_top.f -----
rtl/derb_pkg.sv
rtl/derb_engine.sv
rtl/double_ended_ring_buffer_top.sv
bench/tb_double_ended_ring_buffer_top.sv
